@@ hw/rtl/qgram_profile_distance_macros.svh @@
// ----------------------------------------------------------------------------
// qgram_profile_distance_macros.svh
// Assertion helpers for the q-gram profile distance RTL.
// ----------------------------------------------------------------------------
`ifndef QGRAM_PROFILE_DISTANCE_MACROS_SVH
`define QGRAM_PROFILE_DISTANCE_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset
`define QPD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("%m: implication check failed");

// Next-cycle implication, clocked on aclk, off during reset
`define QPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("%m: next-cycle check failed");

`endif

@@ hw/rtl/qpd_pkg.sv @@
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared types and constants for the q-gram profile distance block.
// ----------------------------------------------------------------------------
package qpd_pkg;

    // Default sizing
    localparam int HIST_DEPTH_DEF = 4096;
    localparam int MAX_GRAM_DEF   = 12;

    // Field widths
    localparam int SYM_W      = 4;
    localparam int GRAM_W     = 4;
    localparam int ALPHA_W    = 5;
    localparam int CNT_W      = 18;
    localparam int DIST_W     = 18;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    // Bin and sum limits
    localparam logic signed [CNT_W-1:0] CNT_MAX  = 18'sh1FFFF;
    localparam logic signed [CNT_W-1:0] CNT_MIN  = 18'sh20000;
    localparam logic [DIST_W-1:0]       DIST_MAX = 18'h3FFFF;

    // Register reset values and alphabet clamp
    localparam logic [GRAM_W-1:0]  GRAM_RST  = 4'd3;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 5'd4;
    localparam logic [ALPHA_W-1:0] ALPHA_MIN = 5'd2;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 5'd16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRAM_LENGTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_SIZE = 1'b1;

    // Input operations
    typedef enum logic [1:0] {
        OP_SYM_A  = 2'd0,
        OP_SYM_B  = 2'd1,
        OP_FINISH = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // Control of the shared multiply-add unit
    typedef struct packed {
        logic load;      // restart accumulator at zero
        logic step;      // acc <= acc * alpha + digit
    } mac_ctrl_t;

endpackage

@@ hw/rtl/qpd_mac.sv @@
// ----------------------------------------------------------------------------
// qpd_mac
// Shared multiply-add unit: one Horner step per cycle, with a sticky flag
// once the accumulated value reaches the histogram depth.
// ----------------------------------------------------------------------------
module qpd_mac
    import qpd_pkg::*;
#(
    parameter int HIST_DEPTH = HIST_DEPTH_DEF,
    localparam int AW = $clog2(HIST_DEPTH)
) (
    input  logic               aclk,
    input  mac_ctrl_t          ctrl,
    input  logic [ALPHA_W-1:0] alpha,
    input  logic [SYM_W-1:0]   digit,
    output logic [AW-1:0]      acc,
    output logic               big
);

    localparam int PW = AW + ALPHA_W + 1;

    logic [AW-1:0] acc_reg;
    logic          big_reg;
    logic [PW-1:0] sum;
    logic          over;

    // Horner step; value never shrinks, so the flag is sticky
    assign sum  = PW'(acc_reg) * PW'(alpha) + PW'(digit);
    assign over = (sum >= PW'(HIST_DEPTH));

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            acc_reg <= '0;
            big_reg <= 1'b0;
        end else if (ctrl.step) begin
            if (!over && !big_reg) begin
                acc_reg <= sum[AW-1:0];
            end
            big_reg <= big_reg | over;
        end
    end

    assign acc = acc_reg;
    assign big = big_reg;

endmodule

@@ hw/rtl/qpd_hist_ram.sv @@
// ----------------------------------------------------------------------------
// qpd_hist_ram
// Single-port difference histogram store with registered read data.
// ----------------------------------------------------------------------------
module qpd_hist_ram
    import qpd_pkg::*;
#(
    parameter int HIST_DEPTH = HIST_DEPTH_DEF,
    localparam int AW = $clog2(HIST_DEPTH)
) (
    input  logic                    aclk,
    input  logic                    we,
    input  logic [AW-1:0]           addr,
    input  logic signed [CNT_W-1:0] wdata,
    output logic signed [CNT_W-1:0] rdata
);

    logic signed [CNT_W-1:0] mem [HIST_DEPTH];
    logic signed [CNT_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/qgram_profile_distance.sv @@
// ----------------------------------------------------------------------------
// qgram_profile_distance
// q-gram profile distance: a signed difference histogram over the q-grams of
// two symbol sequences, with a running L1 sum reported on finish.
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | s_valid s_ready s_op s_symbol s_first  | in
//  result  | m_valid m_ready m_distance m_overflow  | out
//  config  | cfg_we cfg_index cfg_wdata             | in
//
//  Symbol with window not yet full: taken and back in idle. With a full window:
//  q Horner steps on the shared multiply-add unit, then histogram read, update.
//  Finish: q Horner steps over all-largest digits (alpha^q - 1 against the
//  depth), then the hand-over of the result (held off while the result
//  register is still held), then a clear sweep over every entry of the store.
//  After reset the store is cleared over all HIST_DEPTH entries; s_ready stays low.
//  Op 3 is taken and dropped.
// ----------------------------------------------------------------------------
`include "qgram_profile_distance_macros.svh"

module qgram_profile_distance
    import qpd_pkg::*;
#(
    parameter int HIST_DEPTH = HIST_DEPTH_DEF,
    parameter int MAX_GRAM   = MAX_GRAM_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [SYM_W-1:0]      s_symbol,
    input  logic                  s_first,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DIST_W-1:0]     m_distance,
    output logic                  m_overflow,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW    = $clog2(HIST_DEPTH);
    localparam int Q_W   = $clog2(MAX_GRAM + 1);
    localparam int IDX_W = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
    localparam int WIN_W = SYM_W * MAX_GRAM;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CODE,
        S_RD,
        S_UPD,
        S_POW,
        S_OUT,
        S_CLR
    } state_t;

    state_t              state_reg;
    logic [GRAM_W-1:0]   gram_reg;
    logic [ALPHA_W-1:0]  alpha_reg;
    logic [WIN_W-1:0]    win_reg;
    logic [Q_W-1:0]      fill_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [AW-1:0]       ptr_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic                ov_reg;
    logic                is_b_reg;
    logic                m_valid_reg;
    logic [DIST_W-1:0]   m_distance_reg;
    logic                m_overflow_reg;

    logic                accept;
    op_t                 op_in;
    logic [Q_W-1:0]      q_eff;
    logic [ALPHA_W-1:0]  alpha_eff;
    logic [Q_W-1:0]      fill_base;
    logic [Q_W-1:0]      fill_next;
    logic [WIN_W-1:0]    win_base;
    logic [WIN_W-1:0]    win_next;
    logic                out_free;

    mac_ctrl_t           mac_ctrl;
    logic [SYM_W-1:0]    mac_digit;
    logic [AW-1:0]       mac_acc;
    logic                mac_big;

    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic signed [CNT_W-1:0] ram_wdata;
    logic signed [CNT_W-1:0] ram_rdata;

    logic signed [CNT_W-1:0] bin_new;
    logic                bin_sat;
    logic                bin_grow;

    assign accept   = s_valid && s_ready;
    assign op_in    = op_t'(s_op);
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Effective gram length and alphabet size
    always_comb begin
        if (gram_reg == '0) begin
            q_eff = Q_W'(1);
        end else if (5'(gram_reg) > 5'(MAX_GRAM)) begin
            q_eff = Q_W'(MAX_GRAM);
        end else begin
            q_eff = Q_W'(gram_reg);
        end
        if (alpha_reg < ALPHA_MIN) begin
            alpha_eff = ALPHA_MIN;
        end else if (alpha_reg > ALPHA_MAX) begin
            alpha_eff = ALPHA_MAX;
        end else begin
            alpha_eff = alpha_reg;
        end
    end

    // Window shift and fill, restarted by first
    assign fill_base = s_first ? '0 : fill_reg;
    assign fill_next = (fill_base < q_eff) ? fill_base + Q_W'(1) : q_eff;
    assign win_base  = s_first ? '0 : win_reg;
    assign win_next  = WIN_W'({win_base, s_symbol});

    // Shared unit control: code from the window, or alpha^q - 1 on finish
    always_comb begin
        mac_ctrl      = '0;
        mac_ctrl.load = accept;
        mac_ctrl.step = (state_reg == S_CODE) || (state_reg == S_POW);
        if (state_reg == S_CODE) begin
            mac_digit = win_reg[SYM_W*idx_reg +: SYM_W];
        end else begin
            mac_digit = SYM_W'(alpha_eff - ALPHA_W'(1));
        end
    end

    // Bin update: saturate at the count limits
    assign bin_sat  = is_b_reg ? (ram_rdata == CNT_MIN) : (ram_rdata == CNT_MAX);
    assign bin_new  = is_b_reg ? ram_rdata - CNT_W'(1) : ram_rdata + CNT_W'(1);
    assign bin_grow = is_b_reg ? (ram_rdata <= 0) : (ram_rdata >= 0);

    // Store port: read at code, write back update, or clear sweep
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = mac_acc;
        ram_wdata = bin_new;
        case (state_reg)
            S_UPD: begin
                ram_we = !bin_sat;
            end
            S_CLR: begin
                ram_we    = 1'b1;
                ram_addr  = ptr_reg;
                ram_wdata = '0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer, window state, sum and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            gram_reg    <= GRAM_RST;
            alpha_reg   <= ALPHA_RST;
            win_reg     <= '0;
            fill_reg    <= '0;
            idx_reg     <= '0;
            ptr_reg     <= '0;
            dist_reg    <= '0;
            ov_reg      <= 1'b0;
            is_b_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_GRAM_LENGTH:   gram_reg  <= cfg_wdata[GRAM_W-1:0];
                    REG_ALPHABET_SIZE: alpha_reg <= cfg_wdata;
                    default:           gram_reg  <= gram_reg;
                endcase
            end

            // result transfer; S_OUT reloads the register itself
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        idx_reg  <= IDX_W'(q_eff - Q_W'(1));
                        is_b_reg <= (op_in == OP_SYM_B);
                        case (op_in)
                            OP_SYM_A, OP_SYM_B: begin
                                win_reg  <= win_next;
                                fill_reg <= fill_next;
                                if (fill_next == q_eff) begin
                                    state_reg <= S_CODE;
                                end
                            end
                            OP_FINISH: begin
                                state_reg <= S_POW;
                            end
                            default: begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CODE, S_POW: begin
                    if (idx_reg == '0) begin
                        state_reg <= (state_reg == S_CODE) ? S_RD : S_OUT;
                    end else begin
                        idx_reg <= idx_reg - IDX_W'(1);
                    end
                end
                S_RD: begin
                    // code outside the store: no bin changes
                    if (mac_big) begin
                        ov_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (bin_sat || dist_reg == DIST_MAX) begin
                        ov_reg <= 1'b1;
                    end else if (bin_grow) begin
                        dist_reg <= dist_reg + DIST_W'(1);
                    end else if (dist_reg != '0) begin
                        dist_reg <= dist_reg - DIST_W'(1);
                    end
                    state_reg <= S_IDLE;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_distance_reg <= dist_reg;
                        m_overflow_reg <= ov_reg | mac_big;
                        win_reg        <= '0;
                        fill_reg       <= '0;
                        dist_reg       <= '0;
                        ov_reg         <= 1'b0;
                        ptr_reg        <= '0;
                        state_reg      <= S_CLR;
                    end
                end
                S_CLR: begin
                    if (ptr_reg == AW'(HIST_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        ptr_reg <= ptr_reg + AW'(1);
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_distance = m_distance_reg;
    assign m_overflow = m_overflow_reg;

    qpd_mac #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_mac (
        .aclk  (aclk),
        .ctrl  (mac_ctrl),
        .alpha (alpha_eff),
        .digit (mac_digit),
        .acc   (mac_acc),
        .big   (mac_big)
    );

    qpd_hist_ram #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Checks
    `QPD_ASSERT_IMP(a_upd_in_range, state_reg == S_UPD, !mac_big)
    `QPD_ASSERT_NEXT(a_sum_quiet, state_reg != S_UPD && state_reg != S_OUT, $stable(dist_reg))
    `QPD_ASSERT_IMP(a_result_from_out, $rose(m_valid_reg), $past(state_reg == S_OUT))

endmodule

@@ sim/qgram_checker.sv @@
// ----------------------------------------------------------------------------
// qgram_checker
// Watches the input, result and configuration ports of the q-gram profile
// distance block. It keeps its own difference histogram, gram window and
// running L1 sum, and queues the result that each accepted finish should
// produce. Each result transfer is checked field by field against the oldest
// queued result.
// ----------------------------------------------------------------------------
module qgram_checker
    import qpd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [SYM_W-1:0]      s_symbol,
    input  logic                  s_first,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [DIST_W-1:0]     m_distance,
    input  logic                  m_overflow,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } profile_result_t;

    // Shadow of the block state
    logic signed [CNT_W-1:0] diff_bins [HIST_DEPTH_DEF];
    logic [63:0]             gram_window;
    int unsigned             gram_fill;
    logic [DIST_W-1:0]       l1_sum;
    logic                    saturated;
    logic [GRAM_W-1:0]       gram_len_reg;
    logic [ALPHA_W-1:0]      alpha_reg;

    profile_result_t expected_profiles [$];
    int              mismatches = 0;

    // q after clamping: 0 acts as 1, above the maximum acts as the maximum
    function automatic int unsigned active_gram_len();
        if (gram_len_reg == 0) return 1;
        if (gram_len_reg > MAX_GRAM_DEF) return MAX_GRAM_DEF;
        return gram_len_reg;
    endfunction

    function automatic longint unsigned active_alphabet();
        if (alpha_reg < ALPHA_MIN) return ALPHA_MIN;
        if (alpha_reg > ALPHA_MAX) return ALPHA_MAX;
        return alpha_reg;
    endfunction

    // alphabet^q beyond the histogram depth
    function automatic bit profile_store_exceeded();
        longint unsigned span;
        span = 1;
        for (int i = 0; i < active_gram_len(); i++) begin
            span = span * active_alphabet();
            if (span > HIST_DEPTH_DEF) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void clear_profiles();
        foreach (diff_bins[i]) diff_bins[i] = '0;
        gram_window = '0;
        gram_fill   = 0;
        l1_sum      = '0;
        saturated   = 1'b0;
    endfunction

    // One gram moves its bin by one; the sum follows the change in magnitude
    function automatic void count_gram(longint unsigned code, bit from_b);
        int old_v;
        int new_v;
        int old_m;
        int new_m;
        if (code >= HIST_DEPTH_DEF) begin
            saturated = 1'b1;
            return;
        end
        old_v = diff_bins[code];
        if (!from_b) begin
            if (old_v >= int'(CNT_MAX)) begin
                saturated = 1'b1;
                return;
            end
            new_v = old_v + 1;
        end else begin
            if (old_v <= int'(CNT_MIN)) begin
                saturated = 1'b1;
                return;
            end
            new_v = old_v - 1;
        end
        diff_bins[code] = new_v[CNT_W-1:0];
        if (l1_sum == DIST_MAX) begin
            saturated = 1'b1;
            return;
        end
        old_m = (old_v < 0) ? -old_v : old_v;
        new_m = (new_v < 0) ? -new_v : new_v;
        if (new_m > old_m) l1_sum = l1_sum + 1'b1;
        else if (l1_sum != 0) l1_sum = l1_sum - 1'b1;
    endfunction

    function automatic void take_item(op_t op, logic [SYM_W-1:0] sym, logic first);
        longint unsigned code;
        int unsigned     q;
        case (op)
            OP_FINISH: begin
                expected_profiles.push_back('{distance: l1_sum,
                    overflow: saturated || profile_store_exceeded()});
                clear_profiles();
            end
            OP_NOP: begin
            end
            default: begin
                q = active_gram_len();
                if (first) begin
                    gram_window = '0;
                    gram_fill   = 0;
                end
                gram_window = {gram_window[59:0], sym};
                if (gram_fill < q) gram_fill++;
                if (gram_fill > q) gram_fill = q;
                if (gram_fill == q) begin
                    // oldest symbol is the most significant digit
                    code = 0;
                    for (int i = q; i > 0; i--)
                        code = code * active_alphabet() + gram_window[4*(i-1) +: 4];
                    count_gram(code, op == OP_SYM_B);
                end
            end
        endcase
    endfunction

    task automatic check_result();
        profile_result_t want;
        if (expected_profiles.size() == 0) begin
            $error("result transfer with no finish outstanding: distance %0d overflow %0d",
                   m_distance, m_overflow);
            mismatches++;
        end else begin
            want = expected_profiles.pop_front();
            if (m_distance !== want.distance) begin
                $error("distance: expected %0d, actual %0d", want.distance, m_distance);
                mismatches++;
            end
            if (m_overflow !== want.overflow) begin
                $error("overflow: expected %0d, actual %0d", want.overflow, m_overflow);
                mismatches++;
            end
        end
    endtask

    // Sample every port at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_profiles();
            gram_len_reg = GRAM_RST;
            alpha_reg    = ALPHA_RST;
            expected_profiles.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_GRAM_LENGTH:   gram_len_reg = cfg_wdata[GRAM_W-1:0];
                    REG_ALPHABET_SIZE: alpha_reg    = cfg_wdata[ALPHA_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) take_item(op_t'(s_op), s_symbol, s_first);
            if (m_valid && m_ready) check_result();
        end
        pending    <= expected_profiles.size();
        fail_count <= mismatches;
    end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the q-gram profile distance block: a short directed run at the
// reset configuration, then random sequence pairs under a series of gram
// lengths and alphabet sizes (out-of-range values included) and a long result
// back-pressure stretch. Checking is done by qgram_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import qpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLEAR_CYCLES    = HIST_DEPTH_DEF + 64;
    localparam int PHASES          = 10;
    localparam int HOLD_PHASE      = 8;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int HOLD_CYCLES     = 12000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_op      = OP_NOP;
    logic [SYM_W-1:0]      s_symbol  = '0;
    logic                  s_first   = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [DIST_W-1:0]     m_distance;
    logic                  m_overflow;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_GRAM_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int n_fail;
    int n_pending;

    // Register settings per phase; phase 0 runs at the reset values
    int gram_list  [PHASES] = '{3, 1, 12, 12, 4, 0, 15, 6, 2, 5};
    int alpha_list [PHASES] = '{4, 2, 2, 16, 16, 1, 31, 4, 9, 5};

    int               cur_q     = 3;
    int               cur_alpha = 4;
    int               sent_items;
    bit               tx_burst  = 1'b0;
    bit               rx_burst  = 1'b0;
    bit               hold_req  = 1'b0;
    logic [SYM_W-1:0] a_syms [$];
    logic [SYM_W-1:0] b_syms [$];

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    qgram_profile_distance dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_symbol   (s_symbol),
        .s_first    (s_first),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_distance (m_distance),
        .m_overflow (m_overflow),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    qgram_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_symbol   (s_symbol),
        .s_first    (s_first),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_distance (m_distance),
        .m_overflow (m_overflow),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (n_fail),
        .pending    (n_pending)
    );

    // One input transfer, after a random gap unless in a burst
    task automatic send_item(op_t op, logic [SYM_W-1:0] sym, logic first);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_op     <= op;
        s_symbol <= sym;
        s_first  <= first;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (op != OP_NOP) sent_items++;
    endtask

    // Mostly legal symbols, sometimes any code
    function automatic logic [SYM_W-1:0] pick_symbol();
        if ($urandom_range(0, 99) < 85) return SYM_W'($urandom_range(0, cur_alpha - 1));
        return SYM_W'($urandom_range(0, 15));
    endfunction

    // One sequence in five is shorter than q
    function automatic int draw_length();
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, cur_q - 1);
        return $urandom_range(cur_q, cur_q + 20);
    endfunction

    task automatic send_sequence(op_t op, bit use_b);
        int   len;
        logic first;
        logic [SYM_W-1:0] sym;
        len = use_b ? b_syms.size() : a_syms.size();
        for (int i = 0; i < len; i++) begin
            // stray op 3 items as noise
            if ($urandom_range(0, 24) == 0)
                send_item(OP_NOP, pick_symbol(), 1'($urandom_range(0, 1)));
            // usually a clean start, sometimes carry on or restart mid-way
            if (i == 0) first = ($urandom_range(0, 9) != 0);
            else first = ($urandom_range(0, 39) == 0);
            sym = use_b ? b_syms[i] : a_syms[i];
            send_item(op, sym, first);
        end
    endtask

    // Sequence A, sequence B (often a copy or near copy of A), then finish
    task automatic send_profile_pair();
        int pick;
        int len;
        tx_burst = ($urandom_range(0, 3) == 0);
        a_syms.delete();
        b_syms.delete();
        len = draw_length();
        repeat (len) a_syms.push_back(pick_symbol());
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            b_syms = a_syms;
        end else if (pick < 5 && a_syms.size() > 0) begin
            b_syms = a_syms;
            b_syms[$urandom_range(0, b_syms.size() - 1)] = pick_symbol();
        end else begin
            len = draw_length();
            repeat (len) b_syms.push_back(pick_symbol());
        end
        send_sequence(OP_SYM_A, 1'b0);
        send_sequence(OP_SYM_B, 1'b1);
        send_item(OP_FINISH, SYM_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    // Drain all results, then let the store clear finish
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (CLEAR_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(int q, int alpha);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GRAM_LENGTH;
        cfg_wdata <= CFG_DATA_W'(q);
        @(posedge aclk);
        cfg_index <= REG_ALPHABET_SIZE;
        cfg_wdata <= CFG_DATA_W'(alpha);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_q     = (q == 0) ? 1 : (q > MAX_GRAM_DEF) ? MAX_GRAM_DEF : q;
        cur_alpha = (alpha < ALPHA_MIN) ? ALPHA_MIN : (alpha > ALPHA_MAX) ? ALPHA_MAX : alpha;
    endtask

    // Result side: random stalls, occasional bursts, one long hold on request
    initial begin
        int wait_cycles;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                wait_cycles = HOLD_CYCLES;
            end else begin
                wait_cycles = rx_burst ? 0 : $urandom_range(0, 8);
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        settle();

        // Directed: grams at q=3, alphabet 4
        send_item(OP_SYM_A, 4'd0, 1'b1);
        send_item(OP_SYM_A, 4'd1, 1'b0);
        send_item(OP_SYM_A, 4'd2, 1'b0);
        send_item(OP_SYM_A, 4'd3, 1'b0);
        send_item(OP_SYM_A, 4'd15, 1'b0);      // symbol beyond the alphabet
        send_item(OP_NOP, 4'd9, 1'b1);         // dropped
        send_item(OP_SYM_B, 4'd0, 1'b1);
        send_item(OP_SYM_B, 4'd1, 1'b0);
        send_item(OP_SYM_B, 4'd2, 1'b0);       // cancels the first A gram
        send_item(OP_FINISH, 4'd7, 1'b1);
        // both sequences too short for a gram
        send_item(OP_SYM_A, 4'd2, 1'b1);
        send_item(OP_SYM_A, 4'd1, 1'b0);
        send_item(OP_SYM_B, 4'd3, 1'b1);
        send_item(OP_FINISH, 4'd0, 1'b0);
        // window runs on from A into B without a restart
        send_item(OP_SYM_A, 4'd3, 1'b1);
        send_item(OP_SYM_A, 4'd3, 1'b0);
        send_item(OP_SYM_B, 4'd3, 1'b0);
        send_item(OP_FINISH, 4'd15, 1'b0);

        // Random pairs over the register settings
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                configure(gram_list[p], alpha_list[p]);
            end
            if (p == HOLD_PHASE) hold_req = 1'b1;
            sent_items = 0;
            while (sent_items < ITEMS_PER_PHASE) send_profile_pair();
        end

        settle();
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
